// ===== rtl/touch_slider_position_tracker_core_macros.svh =====
// Assertion helpers shared by the slider tracker modules.
// Both expect clk and rst_n in scope; the report text is passed in as a string.
`ifndef TOUCH_SLIDER_POSITION_TRACKER_CORE_MACROS_SVH
`define TOUCH_SLIDER_POSITION_TRACKER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TSPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TSPT_ASSERT_NOW(lbl, ante, cons, msg)
`define TSPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tspt_pkg.sv =====
`default_nettype none
package tspt_pkg;

  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SUM_W      = COUNT_W + 1;
  localparam int unsigned DIVIDEND_W = 24;
  localparam int unsigned DIVISOR_W  = SUM_W;
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned SHIFT_W    = DIVISOR_W + QUO_W - 1;
  localparam int unsigned STEP_W     = $clog2(QUO_W);

  localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

  // Kind of input word
  localparam logic OP_CALIBRATE = 1'b0;
  localparam logic OP_MEASURE   = 1'b1;

  typedef enum logic [1:0] {
    REG_THR_FIRST  = 2'd0,
    REG_THR_SECOND = 2'd1,
    REG_LENGTH     = 2'd2,
    REG_NO_TOUCH   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOAD,
    ST_WAIT,
    ST_DONE
  } state_t;

  // Which quotient the shared divider is producing
  typedef enum logic [1:0] {
    DIV_P0 = 2'd0,
    DIV_P1 = 2'd1,
    DIV_X0 = 2'd2,
    DIV_X1 = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/touch_slider_position_tracker_core.sv =====
`default_nettype none
// Two-electrode capacitive slider tracker. Each input word carries one scan count
// for the current channel (channels rotate 0 .. NUM_CHANNELS-1) and a kind bit in
// tuser: calibrate stores the count as baseline, measure stores the count minus the
// baseline, clamped at zero, as the channel delta. Every word gives one result
// word: the touch flag in tuser, and position in percent and in length units plus
// the stored delta in tdata; with no touch both positions carry the no-touch code.
// An untouched item goes from evaluation straight to the result; a touched item
// first runs one 8-step restoring divider four times in turn (two percent shares,
// then two length scalings). No new word is taken until the result is loaded. The result
// sits in an output register, so the next word may be taken while it waits.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; write
// them only while the block is idle, as the block itself does not enforce this.
`include "touch_slider_position_tracker_core_macros.svh"
module touch_slider_position_tracker_core #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample_count
  input  wire logic [0:0]  in_tuser,   // [0] operation
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [7:0] position_percent, [15:8] position_distance,
                                       // [31:16] channel_delta
  output logic      [0:0]  out_tuser,  // [0] touched
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  tspt_pkg::state_t   state_r;
  tspt_pkg::state_t   state_nxt;
  tspt_pkg::div_sel_t sel_r;
  tspt_pkg::div_req_t div_req;
  tspt_pkg::div_rsp_t div_rsp;

  logic [tspt_pkg::COUNT_W-1:0] thr_first_r;
  logic [tspt_pkg::COUNT_W-1:0] thr_second_r;
  logic [tspt_pkg::LEN_W-1:0]   len_r;
  logic [tspt_pkg::CODE_W-1:0]  no_touch_r;

  logic [tspt_pkg::COUNT_W-1:0] delta_first;
  logic [tspt_pkg::COUNT_W-1:0] delta_second;
  logic [tspt_pkg::COUNT_W-1:0] chan_delta;
  logic                         in_acc;
  logic                         touch;
  logic                         touched_r;
  logic [tspt_pkg::SUM_W-1:0]   sum_r;
  logic [tspt_pkg::PCT_W-1:0]   p0_r;
  logic [tspt_pkg::PCT_W-1:0]   p1_r;
  logic [tspt_pkg::LEN_W-1:0]   x0_r;
  logic [tspt_pkg::LEN_W-1:0]   x1_r;

  logic [tspt_pkg::COUNT_W-1:0] mul_a;
  logic [tspt_pkg::LEN_W-1:0]   mul_b;
  logic [tspt_pkg::CODE_W-1:0]  pct_sum;
  logic [tspt_pkg::LEN_W:0]     dist_sum;
  logic                         out_load;

  logic                         out_valid_r;
  logic                         out_touch_r;
  logic [tspt_pkg::CODE_W-1:0]  out_pct_r;
  logic [tspt_pkg::LEN_W-1:0]   out_dist_r;
  logic [tspt_pkg::COUNT_W-1:0] out_delta_r;

  assign in_acc = in_tvalid && in_tready;

  // Channel baselines and deltas
  tspt_store #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (in_acc),
    .op           (in_tuser[0]),
    .count        (in_tdata),
    .delta_first  (delta_first),
    .delta_second (delta_second),
    .chan_delta   (chan_delta)
  );

  // Shared divider for both percent shares and both length scalings
  tspt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_first_r  <= 16'd100;
      thr_second_r <= 16'd100;
      len_r        <= 8'd40;
      no_touch_r   <= 8'd255;
    end else if (cfg_we) begin
      case (tspt_pkg::cfg_reg_t'(cfg_index))
        tspt_pkg::REG_THR_FIRST:  thr_first_r  <= cfg_wdata;
        tspt_pkg::REG_THR_SECOND: thr_second_r <= cfg_wdata;
        tspt_pkg::REG_LENGTH:     len_r        <= cfg_wdata[tspt_pkg::LEN_W-1:0];
        tspt_pkg::REG_NO_TOUCH:   no_touch_r   <= cfg_wdata[tspt_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign touch = (delta_first > thr_first_r) || (delta_second > thr_second_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tspt_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = tspt_pkg::ST_EVAL;
      end
      tspt_pkg::ST_EVAL: begin
        state_nxt = touch ? tspt_pkg::ST_LOAD : tspt_pkg::ST_DONE;
      end
      tspt_pkg::ST_LOAD: begin
        state_nxt = tspt_pkg::ST_WAIT;
      end
      tspt_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (sel_r == tspt_pkg::DIV_X1) ? tspt_pkg::ST_DONE : tspt_pkg::ST_LOAD;
        end
      end
      tspt_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = tspt_pkg::ST_IDLE;
      end
      default: state_nxt = tspt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, multiplier operands, divider request
  always_comb begin
    in_tready = (state_r == tspt_pkg::ST_IDLE);
    out_load  = (state_r == tspt_pkg::ST_DONE) && (!out_valid_r || out_tready);
    case (sel_r)
      tspt_pkg::DIV_P0: begin
        mul_a = delta_first;
        mul_b = tspt_pkg::LEN_W'(tspt_pkg::PERCENT_FULL);
      end
      tspt_pkg::DIV_P1: begin
        mul_a = delta_second;
        mul_b = tspt_pkg::LEN_W'(tspt_pkg::PERCENT_FULL);
      end
      tspt_pkg::DIV_X0: begin
        mul_a = tspt_pkg::COUNT_W'(p0_r);
        mul_b = len_r;
      end
      default: begin
        mul_a = tspt_pkg::COUNT_W'(p1_r);
        mul_b = len_r;
      end
    endcase
    div_req.start    = (state_r == tspt_pkg::ST_LOAD);
    div_req.dividend = tspt_pkg::DIVIDEND_W'(mul_a) * tspt_pkg::DIVIDEND_W'(mul_b);
    if (sel_r == tspt_pkg::DIV_P0 || sel_r == tspt_pkg::DIV_P1) begin
      div_req.divisor = sum_r;
    end else begin
      div_req.divisor = tspt_pkg::DIVISOR_W'(tspt_pkg::PERCENT_FULL);
    end
  end

  // Final combination of the four quotients
  assign pct_sum  = (tspt_pkg::CODE_W'(tspt_pkg::PERCENT_FULL) - tspt_pkg::CODE_W'(p0_r))
                    + tspt_pkg::CODE_W'(p1_r);
  assign dist_sum = ({1'b0, len_r} - {1'b0, x0_r}) + {1'b0, x1_r};

  // Sequencer state and step select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tspt_pkg::ST_IDLE;
      sel_r   <= tspt_pkg::DIV_P0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tspt_pkg::ST_EVAL) begin
        sel_r <= tspt_pkg::DIV_P0;
      end else if (state_r == tspt_pkg::ST_WAIT && div_rsp.done) begin
        sel_r <= tspt_pkg::div_sel_t'(sel_r + 1'b1);
      end
    end
  end

  // Hold touch flag, delta sum and quotients
  always_ff @(posedge clk) begin
    if (state_r == tspt_pkg::ST_EVAL) begin
      touched_r <= touch;
      sum_r     <= {1'b0, delta_first} + {1'b0, delta_second};
    end
    if (state_r == tspt_pkg::ST_WAIT && div_rsp.done) begin
      case (sel_r)
        tspt_pkg::DIV_P0: p0_r <= div_rsp.quotient[tspt_pkg::PCT_W-1:0];
        tspt_pkg::DIV_P1: p1_r <= div_rsp.quotient[tspt_pkg::PCT_W-1:0];
        tspt_pkg::DIV_X0: x0_r <= div_rsp.quotient;
        default:          x1_r <= div_rsp.quotient;
      endcase
    end
  end

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_touch_r <= touched_r;
      out_delta_r <= chan_delta;
      if (touched_r) begin
        out_pct_r  <= {1'b0, pct_sum[tspt_pkg::CODE_W-1:1]};
        out_dist_r <= dist_sum[tspt_pkg::LEN_W:1];
      end else begin
        out_pct_r  <= no_touch_r;
        out_dist_r <= no_touch_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_delta_r, out_dist_r, out_pct_r};
  assign out_tuser  = out_touch_r;

  `TSPT_ASSERT_NOW(a_pct_range, out_valid_r && out_touch_r, out_pct_r <= 8'd100, "percent position above full scale")
  `TSPT_ASSERT_NEXT(a_no_touch_short, (state_r == tspt_pkg::ST_EVAL) && !touch, state_r == tspt_pkg::ST_DONE, "untouched item entered the divide sequence")
  `TSPT_ASSERT_NOW(a_div_only_touched, div_req.start, touched_r && (sum_r != '0), "divider started without a touch")

endmodule
`default_nettype wire

// ===== rtl/tspt_store.sv =====
`default_nettype none
module tspt_store #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         upd,
  input  wire logic                         op,
  input  wire logic [tspt_pkg::COUNT_W-1:0] count,
  output logic      [tspt_pkg::COUNT_W-1:0] delta_first,
  output logic      [tspt_pkg::COUNT_W-1:0] delta_second,
  output logic      [tspt_pkg::COUNT_W-1:0] chan_delta
);

  localparam int unsigned CH_W = $clog2(NUM_CHANNELS);

  logic [CH_W-1:0]              ch_r;
  logic [CH_W-1:0]              ch_nxt;
  logic [tspt_pkg::COUNT_W-1:0] base_r [NUM_CHANNELS];
  logic [tspt_pkg::COUNT_W-1:0] delta_r [NUM_CHANNELS];
  logic [tspt_pkg::COUNT_W-1:0] chan_delta_r;
  logic [tspt_pkg::COUNT_W-1:0] diff;

  // Clamp count minus baseline at zero
  always_comb begin
    if (count > base_r[ch_r]) begin
      diff = count - base_r[ch_r];
    end else begin
      diff = '0;
    end
  end

  // Rotate through the channels
  always_comb begin
    if (ch_r == CH_W'(NUM_CHANNELS - 1)) begin
      ch_nxt = '0;
    end else begin
      ch_nxt = ch_r + 1'b1;
    end
  end

  // Update baseline or delta of the current channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r         <= '0;
      chan_delta_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        base_r[i]  <= '0;
        delta_r[i] <= '0;
      end
    end else if (upd) begin
      ch_r <= ch_nxt;
      if (op == tspt_pkg::OP_CALIBRATE) begin
        base_r[ch_r] <= count;
        chan_delta_r <= '0;
      end else begin
        delta_r[ch_r] <= diff;
        chan_delta_r  <= diff;
      end
    end
  end

  assign delta_first  = delta_r[0];
  assign delta_second = delta_r[1];
  assign chan_delta   = chan_delta_r;

endmodule
`default_nettype wire

// ===== rtl/tspt_div.sv =====
`default_nettype none
`include "touch_slider_position_tracker_core_macros.svh"
module tspt_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tspt_pkg::div_req_t req,
  output tspt_pkg::div_rsp_t      rsp
);

  logic [tspt_pkg::DIVIDEND_W-1:0] rem_r;
  logic [tspt_pkg::SHIFT_W-1:0]    ds_r;
  logic [tspt_pkg::QUO_W-1:0]      quo_r;
  logic [tspt_pkg::STEP_W-1:0]     cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic                            ge;

  // One restoring step: compare against the shifted divisor
  assign ge = ({1'b0, rem_r} >= {1'b0, ds_r});

  // Control: busy for one step per quotient bit, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tspt_pkg::STEP_W'(tspt_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract, shift quotient in, advance divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      ds_r  <= {req.divisor, {(tspt_pkg::QUO_W - 1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - ds_r;
      end
      quo_r <= {quo_r[tspt_pkg::QUO_W-2:0], ge};
      ds_r  <= ds_r >> 1;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `TSPT_ASSERT_NOW(a_start_idle, req.start, !busy_r, "divider started while busy")
  `TSPT_ASSERT_NEXT(a_done_after_last, busy_r && (cnt_r == tspt_pkg::STEP_W'(tspt_pkg::QUO_W - 1)), done_r && !busy_r, "divider missed its done pulse")
  `TSPT_ASSERT_NOW(a_rem_bound, busy_r, {1'b0, rem_r} < {ds_r, 1'b0}, "partial remainder out of range")

endmodule
`default_nettype wire
